### sv/scancode_to_ascii_line_editor_defines.svh
// Assertion macros used by the line editor top module.
`ifndef SCANCODE_TO_ASCII_LINE_EDITOR_DEFINES_SVH
`define SCANCODE_TO_ASCII_LINE_EDITOR_DEFINES_SVH
`ifndef SYNTHESIS
`define SCLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define SCLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SCLE_ASSERT(lbl, prop, msg)
`define SCLE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### sv/scle_pkg.sv
// Types, constants and translation tables of the scan code line editor.
package scle_pkg;

    localparam int LINE_DEPTH = 32;
    localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int LEN_W      = $clog2(LINE_DEPTH + 1);
    localparam int CHAR_W     = 7;
    localparam int SC_W       = 8;
    localparam int KIND_W     = 2;
    localparam int MOD_W      = 2;

    localparam logic [SC_W-1:0] SC_SHIFT_L_MAKE  = 8'h2A;
    localparam logic [SC_W-1:0] SC_SHIFT_R_MAKE  = 8'h36;
    localparam logic [SC_W-1:0] SC_SHIFT_L_BREAK = 8'hAA;
    localparam logic [SC_W-1:0] SC_SHIFT_R_BREAK = 8'hB6;
    localparam logic [SC_W-1:0] SC_CAPS_MAKE     = 8'h3A;
    localparam logic [SC_W-1:0] SC_RETURN        = 8'h1C;
    localparam logic [SC_W-1:0] SC_RUBOUT        = 8'h0E;
    localparam logic [SC_W-1:0] SC_TOP           = 8'd57;

    localparam logic [MOD_W-1:0] MOD_NONE  = 2'd0;
    localparam logic [MOD_W-1:0] MOD_SHIFT = 2'd1;
    localparam logic [MOD_W-1:0] MOD_CAPS  = 2'd2;
    localparam logic [MOD_W-1:0] MOD_BOTH  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_ECHO  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LINE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

    typedef logic [CHAR_W-1:0] char_t;

    localparam char_t CH_NEWLINE = 7'h0A;
    localparam char_t CH_LOWER_A = 7'h61;
    localparam char_t CH_LOWER_Z = 7'h7A;

    // Decoded view of one scan code under the current modifier state.
    typedef struct packed {
        logic              mod_write;
        logic [MOD_W-1:0]  mod_next;
        logic              is_enter;
        logic              is_rubout;
        logic              is_char;
        char_t             ch;
    } dec_t;

    localparam char_t XLAT_BASE [0:57] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00, 7'h00, 7'h20
    };

    localparam char_t XLAT_SHIFT [0:57] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
        7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00, 7'h00, 7'h20
    };

    // Caps lock inverts the shift choice for letters only.
    function automatic char_t translate(input logic [5:0] idx,
                                        input logic [MOD_W-1:0] modifier);
        logic  shift_on;
        logic  letter;
        char_t base;
        begin
            base     = XLAT_BASE[idx];
            letter   = (base >= CH_LOWER_A) && (base <= CH_LOWER_Z);
            shift_on = modifier[0] ^ (letter & modifier[1]);
            translate = shift_on ? XLAT_SHIFT[idx] : base;
        end
    endfunction

endpackage

### sv/scle_line_ram.sv
// Line store: one write port and one registered read port.
module scle_line_ram (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [scle_pkg::LINE_AW-1:0] wr_addr,
    input  scle_pkg::char_t              wr_data,
    input  logic                         rd_en,
    input  logic [scle_pkg::LINE_AW-1:0] rd_addr,
    output scle_pkg::char_t              rd_data
);

    scle_pkg::char_t line_mem [0:scle_pkg::LINE_DEPTH-1];
    scle_pkg::char_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/scle_decoder.sv
// Scan code classification, modifier transitions and table translation.
module scle_decoder (
    input  logic [scle_pkg::SC_W-1:0]  scan_code,
    input  logic [scle_pkg::MOD_W-1:0] modifier,
    output scle_pkg::dec_t             dec
);

    logic            in_range;
    scle_pkg::char_t ch_raw;

    assign in_range = (scan_code <= scle_pkg::SC_TOP);
    assign ch_raw   = scle_pkg::translate(in_range ? scan_code[5:0] : 6'd0, modifier);

    always_comb begin
        dec = '0;
        priority if (scan_code == scle_pkg::SC_SHIFT_L_MAKE ||
                     scan_code == scle_pkg::SC_SHIFT_R_MAKE) begin
            dec.mod_write = 1'b1;
            dec.mod_next  = (modifier == scle_pkg::MOD_CAPS) ? scle_pkg::MOD_BOTH
                                                             : scle_pkg::MOD_SHIFT;
        end else if (scan_code == scle_pkg::SC_SHIFT_L_BREAK ||
                     scan_code == scle_pkg::SC_SHIFT_R_BREAK) begin
            dec.mod_write = 1'b1;
            dec.mod_next  = (modifier == scle_pkg::MOD_BOTH) ? scle_pkg::MOD_CAPS
                                                             : scle_pkg::MOD_NONE;
        end else if (scan_code == scle_pkg::SC_CAPS_MAKE) begin
            dec.mod_write = 1'b1;
            unique case (modifier)
                scle_pkg::MOD_SHIFT: dec.mod_next = scle_pkg::MOD_BOTH;
                scle_pkg::MOD_BOTH:  dec.mod_next = scle_pkg::MOD_SHIFT;
                scle_pkg::MOD_CAPS:  dec.mod_next = scle_pkg::MOD_NONE;
                default:             dec.mod_next = scle_pkg::MOD_CAPS;
            endcase
        end else if (scan_code == scle_pkg::SC_RETURN) begin
            dec.is_enter = 1'b1;
            dec.ch       = scle_pkg::CH_NEWLINE;
        end else if (in_range && ch_raw != '0) begin
            dec.ch = ch_raw;
            if (scan_code == scle_pkg::SC_RUBOUT) begin
                dec.is_rubout = 1'b1;
            end else begin
                dec.is_char = 1'b1;
            end
        end else begin
            // Releases, prefixes and keys without a character leave everything unchanged.
            dec = '0;
        end
    end

endmodule

### sv/scancode_to_ascii_line_editor.sv
// A result-producing code is decoded from the registered scan code and loads its result
// once the output register has room; no new code is accepted until the block is idle again.
// Enter: newline echo, then each stored character in turn, read through the registered line store port.
// Reset is synchronous and active low; it clears modifiers, line length and control.
// Line store contents are not cleared; only written entries are ever read.
`include "scancode_to_ascii_line_editor_defines.svh"

module scancode_to_ascii_line_editor (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [scle_pkg::SC_W-1:0]     s_scan_code,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [scle_pkg::KIND_W-1:0]   m_kind,
    output logic [scle_pkg::CHAR_W-1:0]   m_char_code,
    output logic                          m_dropped,
    output logic                          m_last
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_EMPTY  = 3'd2;
    localparam logic [2:0] ST_RDREQ  = 3'd3;
    localparam logic [2:0] ST_RDPUSH = 3'd4;

    logic [2:0]                         state_reg, state_next;
    logic [scle_pkg::SC_W-1:0]          sc_reg;
    logic [scle_pkg::MOD_W-1:0]         mod_reg, mod_next;
    logic [scle_pkg::LEN_W-1:0]         len_reg, len_next;
    logic [scle_pkg::LEN_W-1:0]         idx_reg, idx_next;
    logic                               m_valid_reg, m_valid_next;
    logic [scle_pkg::KIND_W-1:0]        m_kind_reg;
    scle_pkg::char_t                    m_char_code_reg;
    logic                               m_dropped_reg;
    logic                               m_last_reg;

    scle_pkg::dec_t                     dec;
    logic                               s_transfer;
    logic                               can_push;
    logic                               walk_last;
    logic                               line_full;
    logic                               push;
    logic [scle_pkg::KIND_W-1:0]        push_kind;
    scle_pkg::char_t                    push_char;
    logic                               push_drop;
    logic                               push_last;
    logic                               wr_en;
    logic                               rd_en;
    scle_pkg::char_t                    rd_data;

    scle_decoder u_decoder (
        .scan_code (sc_reg),
        .modifier  (mod_reg),
        .dec       (dec)
    );

    scle_line_ram u_line_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (len_reg[scle_pkg::LINE_AW-1:0]),
        .wr_data (dec.ch),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[scle_pkg::LINE_AW-1:0]),
        .rd_data (rd_data)
    );

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_transfer = s_valid && s_ready;
    assign can_push   = !m_valid_reg || m_ready;
    assign walk_last  = ((idx_reg + scle_pkg::LEN_W'(1)) == len_reg);
    assign line_full  = (len_reg >= scle_pkg::LEN_W'(scle_pkg::LINE_DEPTH));

    always_comb begin
        state_next = state_reg;
        mod_next   = mod_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        push       = 1'b0;
        push_kind  = scle_pkg::KIND_ECHO;
        push_char  = dec.ch;
        push_drop  = 1'b0;
        push_last  = 1'b1;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_transfer) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // Wait for room in the output register so every outcome can complete.
                if (can_push) begin
                    state_next = ST_IDLE;
                    if (dec.mod_write) begin
                        mod_next = dec.mod_next;
                    end
                    if (dec.is_enter) begin
                        push      = 1'b1;
                        push_last = 1'b0;
                        idx_next  = '0;
                        state_next = (len_reg == '0) ? ST_EMPTY : ST_RDREQ;
                    end
                    if (dec.is_rubout && len_reg != '0) begin
                        push     = 1'b1;
                        len_next = len_reg - scle_pkg::LEN_W'(1);
                    end
                    if (dec.is_char) begin
                        push = 1'b1;
                        if (line_full) begin
                            push_drop = 1'b1;
                        end else begin
                            wr_en    = 1'b1;
                            len_next = len_reg + scle_pkg::LEN_W'(1);
                        end
                    end
                end
            end
            ST_EMPTY: begin
                if (can_push) begin
                    push       = 1'b1;
                    push_kind  = scle_pkg::KIND_EMPTY;
                    push_char  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_RDREQ: begin
                rd_en      = 1'b1;
                state_next = ST_RDPUSH;
            end
            ST_RDPUSH: begin
                if (can_push) begin
                    push      = 1'b1;
                    push_kind = scle_pkg::KIND_LINE;
                    push_char = rd_data;
                    push_last = walk_last;
                    if (walk_last) begin
                        len_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + scle_pkg::LEN_W'(1);
                        state_next = ST_RDREQ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (push) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mod_reg     <= scle_pkg::MOD_NONE;
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mod_reg     <= mod_next;
            len_reg     <= len_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (s_transfer) begin
            sc_reg <= s_scan_code;
        end
        if (push) begin
            m_kind_reg      <= push_kind;
            m_char_code_reg <= push_char;
            m_dropped_reg   <= push_drop;
            m_last_reg      <= push_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_kind      = m_kind_reg;
    assign m_char_code = m_char_code_reg;
    assign m_dropped   = m_dropped_reg;
    assign m_last      = m_last_reg;

    `SCLE_ASSERT_NEXT(a_transfer_exec, s_transfer,
        state_reg == ST_EXEC && !s_ready, "transfer did not start execution")
    `SCLE_ASSERT(a_len_bound, len_reg <= scle_pkg::LEN_W'(scle_pkg::LINE_DEPTH),
        "line length above depth")
    `SCLE_ASSERT(a_drop_full, (m_valid_reg && m_dropped_reg) |->
        (m_kind_reg == scle_pkg::KIND_ECHO && len_reg == scle_pkg::LEN_W'(scle_pkg::LINE_DEPTH)),
        "dropped flag without a full line")
    `SCLE_ASSERT(a_empty_marker, (m_valid_reg && m_kind_reg == scle_pkg::KIND_EMPTY) |->
        (m_last_reg && m_char_code_reg == '0), "bad empty line marker")
    `SCLE_ASSERT_NEXT(a_walk_clear, state_reg == ST_RDPUSH && can_push && walk_last,
        len_reg == '0 && state_reg == ST_IDLE, "line not cleared after walk-out")

endmodule
